### sv/eqb_pkg.sv
// ============================================================================
// eqb_pkg - shared types and constants
// Sizes, the stored entry type and the cell control struct.
// ============================================================================
package eqb_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int MAX_BINS  = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int NB_W      = 7;
    localparam int DIVN_W    = 12;
    localparam int DIVD_W    = 8;

    localparam logic [2:0] ADDR_NUM_BINS = 3'd0;
    localparam logic [NB_W-1:0] NUM_BINS_RESET = 7'd10;

    typedef struct packed {
        logic signed [31:0] val;
        logic               bad;
    } entry_t;

    typedef struct packed {
        logic ins;       // insert the new request this cycle
        logic shift_dn;  // advance every entry one cell toward the head
    } cell_ctl_t;

endpackage

### sv/eqb_cell.sv
// ============================================================================
// eqb_cell - one slot of the sorted insertion chain
// Holds one entry; shifts up on insert, down on readout.
// ============================================================================
module eqb_cell (
    input  logic                clk,
    input  eqb_pkg::cell_ctl_t  ctl,
    input  eqb_pkg::entry_t     new_item,
    input  eqb_pkg::entry_t     prev_item,
    input  eqb_pkg::entry_t     next_item,
    input  logic                prev_greater,
    input  logic                occ,
    input  logic                at_tail,
    output eqb_pkg::entry_t     item,
    output logic                greater
);

    eqb_pkg::entry_t item_reg;

    assign item    = item_reg;
    assign greater = occ && (item_reg.val > new_item.val);

    always_ff @(posedge clk)
    begin
        if (ctl.shift_dn)
        begin
            item_reg <= next_item;
        end
        else if (ctl.ins)
        begin
            if (prev_greater)
            begin
                item_reg <= prev_item;
            end
            else if (greater || at_tail)
            begin
                item_reg <= new_item;
            end
        end
    end

endmodule

### sv/eqb_div.sv
// ============================================================================
// eqb_div - restoring divider, one quotient bit per cycle
// Computes the bin size quotient for the compute phase.
// ============================================================================
module eqb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [eqb_pkg::DIVN_W-1:0]   num,
    input  logic [eqb_pkg::DIVD_W-1:0]   den,
    output logic                         done,
    output logic [eqb_pkg::DIVN_W-1:0]   quot
);

    logic                        busy_reg, busy_next;
    logic [3:0]                  step_reg, step_next;
    logic [eqb_pkg::DIVN_W-1:0]  num_reg, num_next;
    logic [eqb_pkg::DIVN_W-1:0]  quot_reg, quot_next;
    logic [eqb_pkg::DIVD_W-1:0]  den_reg, den_next;
    logic [eqb_pkg::DIVD_W-1:0]  rem_reg, rem_next;
    logic [eqb_pkg::DIVD_W:0]    trial;

    // Done once every quotient bit has landed in quot_reg.
    assign quot = quot_reg;
    assign done = busy_reg && (step_reg == 4'(eqb_pkg::DIVN_W));

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[eqb_pkg::DIVN_W-1]};
        if (busy_reg)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                num_next = {num_reg[eqb_pkg::DIVN_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next  = eqb_pkg::DIVD_W'(trial - {1'b0, den_reg});
                    quot_next = {quot_reg[eqb_pkg::DIVN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[eqb_pkg::DIVD_W-1:0];
                    quot_next = {quot_reg[eqb_pkg::DIVN_W-2:0], 1'b0};
                end
                step_next = step_reg + 4'd1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

endmodule

### sv/equal_bads_quantile_binner.sv
// ============================================================================
// equal_bads_quantile_binner - equal-bad-count range builder
// Sorts samples into a cell chain and emits ranges holding equal bad counts.
// ============================================================================
// Samples load at one per cycle into a chain of MAX_ITEMS cells that keeps
// them sorted by value (ties keep arrival order); a full chain drops further
// samples. The sample with tlast set starts the compute phase, during which
// s_tready is low: the serial divider finds the bin size, then the chain
// shifts toward its head one entry per cycle, while m_tready does not stall
// the output, to find the cut points, then the remaining ranges are filled
// in. Exactly num_bins ranges (0 read as 1, above 64 read as 64) come out,
// the final one with m_tlast. The chain needs no clearing pass: a fill count
// tracks the occupied cells.
module equal_bads_quantile_binner (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] is_bad
    input  logic        s_tlast,
    // range results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [5:0] bin_index, [37:6] low_edge, [69:38] high_edge
    output logic        m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    localparam int CW = eqb_pkg::CNT_W;

    logic [1:0]                  state_reg, state_next;
    logic [eqb_pkg::NB_W-1:0]    num_bins_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               bad_reg, bad_next;
    logic [CW-1:0]               walk_reg, walk_next;
    logic [CW-1:0]               run_reg, run_next;
    logic [CW-1:0]               bsize_reg, bsize_next;
    logic [eqb_pkg::NB_W-1:0]    bin_reg, bin_next;
    logic [eqb_pkg::NB_W-1:0]    nb_reg, nb_next;
    logic signed [31:0]          vmin_reg, vmin_next;
    logic signed [31:0]          vmax_reg, vmax_next;
    logic signed [31:0]          prev_reg, prev_next;

    logic                        out_valid_reg, out_valid_next;
    logic [5:0]                  out_idx_reg, out_idx_next;
    logic signed [31:0]          out_lo_reg, out_lo_next;
    logic signed [31:0]          out_hi_reg, out_hi_next;
    logic                        out_last_reg, out_last_next;

    logic                        accept;
    logic                        can_emit;
    logic [eqb_pkg::NB_W-1:0]    nb_clamp;
    logic                        div_start;
    logic                        div_done;
    logic [eqb_pkg::DIVN_W-1:0]  div_quot;
    logic [CW-1:0]               run_inc;
    logic                        hit;

    eqb_pkg::cell_ctl_t          ctl;
    eqb_pkg::entry_t             new_item;
    eqb_pkg::entry_t             cell_item [eqb_pkg::MAX_ITEMS];
    logic                        cell_gt   [eqb_pkg::MAX_ITEMS];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == eqb_pkg::ADDR_NUM_BINS[2])
                    ? {25'd0, num_bins_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg <= eqb_pkg::NUM_BINS_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == eqb_pkg::ADDR_NUM_BINS[2]))
        begin
            num_bins_reg <= pwdata[eqb_pkg::NB_W-1:0];
        end
    end

    // Clamp the range count into 1..MAX_BINS.
    always_comb
    begin
        if (num_bins_reg == '0)
        begin
            nb_clamp = eqb_pkg::NB_W'(1);
        end
        else if (num_bins_reg > eqb_pkg::NB_W'(eqb_pkg::MAX_BINS))
        begin
            nb_clamp = eqb_pkg::NB_W'(eqb_pkg::MAX_BINS);
        end
        else
        begin
            nb_clamp = num_bins_reg;
        end
    end

    // ---------------- handshakes ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_emit = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_hi_reg, out_lo_reg, out_idx_reg};

    // ---------------- sorted cell chain ----------------
    assign new_item.val = s_tdata;
    assign new_item.bad = s_tuser;
    assign ctl.ins      = accept && (count_reg < CW'(eqb_pkg::MAX_ITEMS));
    assign ctl.shift_dn = (state_reg == S_WALK) && can_emit;

    for (genvar i = 0; i < eqb_pkg::MAX_ITEMS; i++)
    begin : g_cell
        eqb_pkg::entry_t prev_i;
        eqb_pkg::entry_t next_i;
        logic            prev_gt_i;

        if (i == 0)
        begin : g_head
            assign prev_i    = new_item;
            assign prev_gt_i = 1'b0;
        end
        else
        begin : g_body
            assign prev_i    = cell_item[i-1];
            assign prev_gt_i = cell_gt[i-1];
        end

        if (i == eqb_pkg::MAX_ITEMS - 1)
        begin : g_tail
            assign next_i = cell_item[i];
        end
        else
        begin : g_mid
            assign next_i = cell_item[i+1];
        end

        eqb_cell u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .new_item     (new_item),
            .prev_item    (prev_i),
            .next_item    (next_i),
            .prev_greater (prev_gt_i),
            .occ          (CW'(i) < count_reg),
            .at_tail      (CW'(i) == count_reg),
            .item         (cell_item[i]),
            .greater      (cell_gt[i])
        );
    end

    // ---------------- bin size divider ----------------
    // bsize = floor((2*bad + nb) / (2*nb))
    assign div_start = (state_reg == S_DIV);

    eqb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (eqb_pkg::DIVN_W'({bad_reg, 1'b0}) + eqb_pkg::DIVN_W'(nb_reg)),
        .den   ({nb_reg, 1'b0}),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- control ----------------
    assign run_inc = run_reg + CW'(1);
    assign hit     = cell_item[0].bad && (run_inc == bsize_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        walk_next      = walk_reg;
        run_next       = run_reg;
        bsize_next     = bsize_reg;
        bin_next       = bin_reg;
        nb_next        = nb_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (ctl.ins)
                    begin
                        count_next = count_reg + CW'(1);
                        bad_next   = bad_reg + CW'(s_tuser);
                        if (count_reg == '0)
                        begin
                            vmin_next = new_item.val;
                            vmax_next = new_item.val;
                        end
                        else
                        begin
                            if (new_item.val < vmin_reg)
                            begin
                                vmin_next = new_item.val;
                            end
                            if (new_item.val > vmax_reg)
                            begin
                                vmax_next = new_item.val;
                            end
                        end
                    end
                    if (s_tlast)
                    begin
                        nb_next    = nb_clamp;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // Latch the bin size and arm the walk (a single range goes straight to the fill).
                if (div_done)
                begin
                    bsize_next = (div_quot == '0) ? CW'(1) : div_quot[CW-1:0];
                    walk_next  = count_reg;
                    run_next   = '0;
                    bin_next   = '0;
                    prev_next  = vmin_reg;
                    state_next = (nb_reg == eqb_pkg::NB_W'(1)) ? S_FILL : S_WALK;
                end
            end
            S_WALK:
            begin
                if (can_emit)
                begin
                    walk_next = walk_reg - CW'(1);
                    if (cell_item[0].bad)
                    begin
                        run_next = hit ? '0 : run_inc;
                    end
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = bin_reg[5:0];
                        out_lo_next    = prev_reg;
                        out_hi_next    = cell_item[0].val;
                        out_last_next  = 1'b0;
                        prev_next      = cell_item[0].val;
                        bin_next       = bin_reg + eqb_pkg::NB_W'(1);
                    end
                    if ((walk_reg == CW'(1)) ||
                        (hit && (bin_reg + eqb_pkg::NB_W'(2) == nb_reg)))
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                // Missing cuts take the maximum.
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = bin_reg[5:0];
                    out_lo_next    = prev_reg;
                    out_hi_next    = vmax_reg;
                    out_last_next  = (bin_reg + eqb_pkg::NB_W'(1) == nb_reg);
                    prev_next      = vmax_reg;
                    bin_next       = bin_reg + eqb_pkg::NB_W'(1);
                    if (bin_reg + eqb_pkg::NB_W'(1) == nb_reg)
                    begin
                        count_next = '0;
                        bad_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg     <= walk_next;
        run_reg      <= run_next;
        bsize_reg    <= bsize_next;
        bin_reg      <= bin_next;
        nb_reg       <= nb_next;
        vmin_reg     <= vmin_next;
        vmax_reg     <= vmax_next;
        prev_reg     <= prev_next;
        out_idx_reg  <= out_idx_next;
        out_lo_reg   <= out_lo_next;
        out_hi_reg   <= out_hi_next;
        out_last_reg <= out_last_next;
    end

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(eqb_pkg::MAX_ITEMS))
        else $error("fill count beyond chain depth");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_reg != '0))
        else $error("walk with nothing left in chain");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_idx_reg == 6'(nb_reg - eqb_pkg::NB_W'(1))))
        else $error("final range has wrong index");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ctl.ins)
        else $error("insert during compute");

endmodule
